/* sv/pspf_pkg.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Shared constants, command and handshake types for the frame parser blocks.
// ----------------------------------------------------------------------------
package pspf_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES = 32;
  localparam logic [7:0] START_BYTE = 8'h42;
  localparam int STORE_DEPTH = 14;
  localparam int RAW_WORDS = (FRAME_BYTES - 4) / 2;
  localparam int WORD_COUNT = (RAW_WORDS < STORE_DEPTH) ? RAW_WORDS : STORE_DEPTH;

  // Widths.
  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int IDX_W = 4;

  // Byte positions with a special role.
  localparam logic [POS_W-1:0] POS_HUNT  = '0;
  localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WORD_COUNT - 1);

  // One finished frame, handed from the front to the back.
  typedef struct packed {
    logic ok;
    logic bank;
  } cmd_t;

  // Back tells the front that a store bank has been fully emitted.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_EMIT
  } back_state_e;

endpackage

/* sv/pspf_front.sv */
// ----------------------------------------------------------------------------
// Frame parser front end
// Hunts for the start byte, sums the frame, assembles words into a two-bank
// store and posts one command per finished frame.
// ----------------------------------------------------------------------------
module pspf_front
  import pspf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       rx_byte_i,
  output logic             full_o,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_ready_i,
  input  release_t         release_i,
  input  logic             rd_bank_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [15:0]      rd_data_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       held_q, held_d;
  logic             wr_bank_q, wr_bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [15:0]      store_q [2][STORE_DEPTH];
  logic [15:0]      rd_data_q;

  logic             accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [POS_W-1:0] off;
  logic [POS_W-2:0] word_num;
  logic [15:0]      check;
  logic             check_ok;

  // Stall on the final byte when the queue is full, and inside a frame whose
  // bank still holds words that the back has not emitted yet.
  assign full_o = ((pos_q == POS_CHK_LO) && !cmd_ready_i) ||
                  (busy_q[wr_bank_q] && (pos_q != POS_HUNT));
  assign accept = push_i && !full_o;

  assign off      = pos_q - POS_W'(2);
  assign word_num = off[POS_W-1:1];
  assign check    = {held_q, rx_byte_i};
  assign check_ok = (check == sum_q);

  // Byte parsing.
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    held_d      = held_q;
    wr_bank_d   = wr_bank_q;
    busy_d      = busy_q;
    wr_en       = 1'b0;
    wr_idx      = IDX_W'(word_num);
    cmd_valid_o = 1'b0;
    cmd_o.ok    = check_ok;
    cmd_o.bank  = wr_bank_q;

    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end

    if (accept) begin
      if (pos_q == POS_HUNT) begin
        if (rx_byte_i == START_BYTE) begin
          sum_d = {8'h00, START_BYTE};
          pos_d = POS_W'(1);
        end
      end else if (pos_q == POS_CHK_LO) begin
        pos_d       = POS_HUNT;
        cmd_valid_o = 1'b1;
        if (check_ok) begin
          busy_d[wr_bank_q] = 1'b1;
          wr_bank_d         = !wr_bank_q;
        end
      end else if (pos_q == POS_CHK_HI) begin
        held_d = rx_byte_i;
        pos_d  = pos_q + POS_W'(1);
      end else begin
        sum_d = sum_q + {8'h00, rx_byte_i};
        if (pos_q >= POS_W'(2)) begin
          if (!off[0]) begin
            held_d = rx_byte_i;
          end else if (int'(word_num) < STORE_DEPTH) begin
            wr_en = 1'b1;
          end
        end
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_HUNT;
      sum_q     <= '0;
      held_q    <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      held_q    <= held_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

  // Word store, two banks so one frame can be emitted while the next fills.
  // The read port is registered; the back supplies the address from its next-state values.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_bank_q][wr_idx] <= {held_q, rx_byte_i};
    end
    rd_data_q <= store_q[rd_bank_i][rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/pspf_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Frame command queue
// Two-entry queue of frame commands between the front and the back.
// ----------------------------------------------------------------------------
module pspf_cmd_fifo
  import pspf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  cmd_t wr_cmd_i,
  output logic wr_ready_o,
  output logic rd_valid_o,
  output cmd_t rd_cmd_o,
  input  logic rd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

/* sv/pspf_back.sv */
// ----------------------------------------------------------------------------
// Frame parser back end
// Takes frame commands and emits the stored words, or one error item, through
// an output register.
// ----------------------------------------------------------------------------
module pspf_back
  import pspf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             rd_bank_o,
  output logic [IDX_W-1:0] rd_idx_o,
  input  logic [15:0]      rd_data_i,
  output release_t         release_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [3:0]       word_index_o,
  output logic [15:0]      word_value_o,
  output logic             checksum_ok_o,
  output logic             last_o
);

  back_state_e      state_q, state_d;
  logic             cur_ok_q, cur_ok_d;
  logic             cur_bank_q, cur_bank_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic             can_load;
  logic             is_last;

  logic [3:0]       index_q;
  logic [15:0]      value_q;
  logic             ok_q;
  logic             last_q;

  assign can_load  = !out_valid_q || pop_i;
  assign is_last   = !cur_ok_q || (idx_q == LAST_IDX);

  // The store read is registered, so the next word's address is presented
  // here and its data arrives together with idx_q.
  assign rd_bank_o = cur_bank_d;
  assign rd_idx_o  = idx_d;

  // Sequencer over the words of one frame.
  always_comb begin
    state_d         = state_q;
    cur_ok_d        = cur_ok_q;
    cur_bank_d      = cur_bank_q;
    idx_d           = idx_q;
    cmd_pop_o       = 1'b0;
    load            = 1'b0;
    release_o.valid = 1'b0;
    release_o.bank  = cur_bank_q;

    unique case (state_q)
      BACK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cur_ok_d   = cmd_i.ok;
          cur_bank_d = cmd_i.bank;
          idx_d      = '0;
          state_d    = BACK_EMIT;
        end
      end
      BACK_EMIT: begin
        if (can_load) begin
          load = 1'b1;
          if (is_last) begin
            release_o.valid = cur_ok_q;
            state_d         = BACK_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !pop_i) || load;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      cur_ok_q    <= 1'b0;
      cur_bank_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_ok_q    <= cur_ok_d;
      cur_bank_q  <= cur_bank_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register; an error item carries index and value zero.
  always_ff @(posedge clk_i) begin
    if (load) begin
      index_q <= cur_ok_q ? idx_q : '0;
      value_q <= cur_ok_q ? rd_data_i : '0;
      ok_q    <= cur_ok_q;
      last_q  <= is_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign word_index_o  = index_q;
  assign word_value_o  = value_q;
  assign checksum_ok_o = ok_q;
  assign last_o        = last_q;

endmodule

/* sv/particle_sensor_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame parser
// Parses 32-byte sensor frames from a byte stream and emits decoded words.
// ----------------------------------------------------------------------------
// Bytes are taken one per clock cycle while full is low. A frame's results
// appear one per cycle while pop keeps taking them: fourteen words with
// checksum_ok set, or a single error item. The front parses bytes into a
// two-bank word store and posts a command to a two-entry queue; the back
// emits from the store through an output register. full rises on the final
// byte of a frame while the queue holds two frames, and inside a frame whose
// store bank still holds words that wait or are being emitted, which happens
// when the result side does not keep up with the byte stream.
module particle_sensor_frame_parser_unit
  import pspf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        checksum_ok_o,
  output logic        last_o
);

  logic             fr_cmd_valid;
  cmd_t             fr_cmd;
  logic             fr_cmd_ready;
  logic             bk_cmd_valid;
  cmd_t             bk_cmd;
  logic             bk_cmd_pop;
  release_t         bank_release;
  logic             rd_bank;
  logic [IDX_W-1:0] rd_idx;
  logic [15:0]      rd_data;

  // Byte parser and word store.
  pspf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .cmd_valid_o (fr_cmd_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (fr_cmd_ready),
    .release_i   (bank_release),
    .rd_bank_i   (rd_bank),
    .rd_idx_i    (rd_idx),
    .rd_data_o   (rd_data)
  );

  // Queue of finished frames.
  pspf_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_cmd_valid),
    .wr_cmd_i   (fr_cmd),
    .wr_ready_o (fr_cmd_ready),
    .rd_valid_o (bk_cmd_valid),
    .rd_cmd_o   (bk_cmd),
    .rd_pop_i   (bk_cmd_pop)
  );

  // Result emitter.
  pspf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (bk_cmd_valid),
    .cmd_i         (bk_cmd),
    .cmd_pop_o     (bk_cmd_pop),
    .rd_bank_o     (rd_bank),
    .rd_idx_o      (rd_idx),
    .rd_data_i     (rd_data),
    .release_o     (bank_release),
    .pop_i         (pop),
    .empty_o       (empty),
    .word_index_o  (word_index_o),
    .word_value_o  (word_value_o),
    .checksum_ok_o (checksum_ok_o),
    .last_o        (last_o)
  );

endmodule

/* sv/pspf_checker.sv */
// ----------------------------------------------------------------------------
// Frame parser port checker
// Checks the result stream of the frame parser as seen at its ports.
// ----------------------------------------------------------------------------
module pspf_checker
  import pspf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  word_index_o,
  input logic [15:0] word_value_o,
  input logic        checksum_ok_o,
  input logic        last_o
);

  // An error item stands alone and carries zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !checksum_ok_o) |->
      (last_o && (word_index_o == 4'd0) && (word_value_o == 16'd0)))
    else $error("error item is malformed");

  // The last word of a good frame has the final index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && checksum_ok_o && last_o) |-> (word_index_o == 4'(WORD_COUNT - 1)))
    else $error("good frame ended at the wrong index");

  // Words of a frame follow each other without a gap, index by index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=>
      (!empty && checksum_ok_o && (word_index_o == $past(word_index_o) + 4'd1)))
    else $error("word burst broke or skipped an index");

  // A waiting item holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(word_index_o) && $stable(word_value_o) && $stable(last_o)))
    else $error("waiting item changed");

endmodule

bind particle_sensor_frame_parser_unit pspf_checker u_pspf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .word_index_o  (word_index_o),
  .word_value_o  (word_value_o),
  .checksum_ok_o (checksum_ok_o),
  .last_o        (last_o)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Frame parser testbench
// Streams sensor frames, noise and damaged frames into the parser and checks
// each decoded word against a cycle-free software copy of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pspf_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYCLES = 7;
  localparam int RAND_BYTES  = 24;
  localparam int RAND_FRAMES = 1;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  // How the data bytes of a generated frame are filled.
  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS,
    FILL_STARTS
  } fill_e;

  // One decoded word as the parser presents it.
  typedef struct {
    logic [3:0]  index;
    logic [15:0] value;
    logic        ok;
    logic        last;
  } word_result_t;

  // Software copy of the parser plus the queue of words it has promised.
  class frame_scoreboard;
    logic [POS_W-1:0] position;
    logic [15:0]      sum;
    logic [7:0]       high_byte;
    logic [15:0]      words [STORE_DEPTH];
    word_result_t     expected_words [$];
    int               errors;

    function new();
      position  = POS_HUNT;
      sum       = '0;
      high_byte = '0;
      errors    = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void push_word(int index, logic [15:0] value, logic ok, logic last);
      word_result_t w;
      w.index = index[3:0];
      w.value = value;
      w.ok    = ok;
      w.last  = last;
      expected_words.push_back(w);
    endfunction

    // Advance the parser copy by one accepted byte.
    function void note_byte(logic [7:0] b);
      int off;
      logic [15:0] check_word;
      if (position == POS_HUNT) begin
        if (b == START_BYTE) begin
          sum      = 16'(b);
          position = POS_W'(1);
        end
      end else if (position == POS_CHK_LO) begin
        check_word = {high_byte, b};
        position   = POS_HUNT;
        if (check_word != sum) begin
          push_word(0, 16'h0000, 1'b0, 1'b1);
        end else begin
          for (int k = 0; k < WORD_COUNT; k++)
            push_word(k, words[k], 1'b1, k == WORD_COUNT - 1);
        end
      end else if (position == POS_CHK_HI) begin
        high_byte = b;
        position  = position + 1'b1;
      end else begin
        sum = sum + 16'(b);
        if (position >= 2) begin
          off = int'(position) - 2;
          if (off % 2 == 0) high_byte = b;
          else if (off / 2 < STORE_DEPTH) words[off / 2] = {high_byte, b};
        end
        position = position + 1'b1;
      end
    endfunction

    // Compare one accepted word with the oldest promised one.
    task check_result(logic [3:0] index, logic [15:0] value, logic ok, logic last);
      word_result_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word index %0d value %h", index, value));
      end else begin
        w = expected_words.pop_front();
        if (index !== w.index)
          report($sformatf("word_index got %0d expected %0d", index, w.index));
        if (value !== w.value)
          report($sformatf("word_value got %h expected %h (index %0d)",
                           value, w.value, w.index));
        if (ok !== w.ok)
          report($sformatf("checksum_ok got %b expected %b", ok, w.ok));
        if (last !== w.last)
          report($sformatf("last got %b expected %b (index %0d)", last, w.last,
                           w.index));
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    task check_drained();
      if (expected_words.size() != 0)
        report($sformatf("%0d expected words never arrived", expected_words.size()));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte_i;
  logic        empty;
  logic        pop;
  logic [3:0]  word_index_o;
  logic [15:0] word_value_o;
  logic        checksum_ok_o;
  logic        last_o;

  frame_scoreboard sb = new();
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int cycles    = 0;
  int rand_bytes = 0;

  particle_sensor_frame_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte_i),
    .empty        (empty),
    .pop          (pop),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .checksum_ok_o(checksum_ok_o),
    .last_o       (last_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one byte until the parser takes it, then maybe idle.
  task automatic send_byte(input logic [7:0] b, input bit no_gap);
    int gap;
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.note_byte(b);
    rand_bytes++;
    gap = (no_gap || (hold_req && !hold_done)) ? 0 : gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Build a frame with a valid or damaged checksum and send its first keep bytes.
  task automatic send_frame(input fill_e fill, input logic [7:0] second,
                            input bit corrupt, input int keep, input bit no_gap);
    logic [7:0]  f [FRAME_BYTES];
    logic [15:0] total;
    f[0]  = START_BYTE;
    f[1]  = second;
    total = '0;
    for (int i = 2; i < FRAME_BYTES - 2; i++) begin
      case (fill)
        FILL_ONES:   f[i] = 8'hFF;
        FILL_ZEROS:  f[i] = 8'h00;
        FILL_STARTS: f[i] = ($urandom_range(0, 1) == 0) ? START_BYTE : 8'($urandom);
        default:     f[i] = 8'($urandom);
      endcase
    end
    for (int i = 0; i < FRAME_BYTES - 2; i++) total = total + 16'(f[i]);
    if (corrupt) total = total ^ 16'($urandom_range(1, 16'hFFFF));
    f[FRAME_BYTES - 2] = total[15:8];
    f[FRAME_BYTES - 1] = total[7:0];
    for (int i = 0; i < keep && i < FRAME_BYTES; i++) send_byte(f[i], no_gap);
  endtask

  // Result side: check accepted words and stall at random.
  initial begin
    int stall;
    stall = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(word_index_o, word_value_o, checksum_ok_o, last_o);
      if (hold_req && !hold_done) begin
        // Long hold-off so the parser backs up and raises full.
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        pop <= 1'b1;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // Byte side: reset, directed frames, random traffic, drain.
  initial begin
    int choice;
    int frames;
    bit burst;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    rx_byte_i <= 8'h00;
    frames     = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed frames and the first random ones go out while the result
    // side holds off, so both banks and the queue fill and full rises.
    hold_req = 1'b1;

    // Noise while hunting, including neighbors of the start byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h43, 1'b1);
    // Maximum data with the usual second start byte.
    send_frame(FILL_ONES, 8'h4D, 1'b0, FRAME_BYTES, 1'b1);
    // Checksum mismatch with an unusual second start byte.
    send_frame(FILL_ZEROS, 8'hFF, 1'b1, FRAME_BYTES, 1'b0);
    // Start bytes inside a frame must not restart it.
    send_frame(FILL_STARTS, START_BYTE, 1'b0, FRAME_BYTES, 1'b0);

    // Random traffic.
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES || frames < RAND_FRAMES) begin
      choice = $urandom_range(0, 99);
      burst  = ($urandom_range(0, 3) == 0);
      if (choice < 70) begin
        send_frame(FILL_RANDOM, 8'($urandom), 1'b0, FRAME_BYTES, burst);
        frames++;
      end else if (choice < 85) begin
        send_frame(FILL_RANDOM, 8'($urandom), 1'b1, FRAME_BYTES, burst);
        frames++;
      end else if (choice < 95) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), burst);
      end else begin
        send_frame(FILL_RANDOM, 8'($urandom), 1'b0, $urandom_range(1, FRAME_BYTES - 1),
                   burst);
      end
    end
    push <= 1'b0;

    while (sb.pending() != 0 || !hold_done) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
